>>> design/bmpse_pkg.sv
`timescale 1ns / 1ps

package bmpse_pkg;

    // Header layout and magic bytes
    localparam int unsigned HEADER_BYTES = 14;
    localparam logic [7:0]  MAGIC_B      = 8'h42;
    localparam logic [7:0]  MAGIC_M      = 8'h4D;

    // Widths fixed by the file format and the register
    localparam int unsigned POS_W        = 32;
    localparam int unsigned PLEN_W       = 29;
    localparam int unsigned NEED_W       = 33;
    localparam int unsigned LENGTH_BITS_DEF = 32;

    typedef enum logic [2:0] {
        ROLE_HEADER = 3'd0,
        ROLE_PRE    = 3'd1,
        ROLE_LEN    = 3'd2,
        ROLE_PAY    = 3'd3,
        ROLE_POST   = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_MAGIC  = 2'd1,
        ERR_OFFSET = 2'd2,
        ERR_SPACE  = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] image_byte;
        logic [7:0] payload_byte;
        logic       file_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        role_t      byte_role;
        err_t       error_code;
        logic       payload_advance;
        logic       out_last;
    } out_item_t;

    // Header parser status seen by the embed datapath
    typedef struct packed {
        err_t        err;
        logic [31:0] pixel_offset;
    } hdr_status_t;

endpackage

>>> design/bmpse_if.sv
`timescale 1ns / 1ps

interface bmpse_in_if;
    logic                valid;
    logic                ready;
    bmpse_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bmpse_out_if;
    logic                 valid;
    logic                 ready;
    bmpse_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/bmpse_hdr.sv
`timescale 1ns / 1ps

module bmpse_hdr
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic                                in_hdr,
    input  logic [3:0]                          pos_lo,
    input  logic [7:0]                          image_byte,
    input  logic [bmpse_pkg::NEED_W-1:0]        need,
    output bmpse_pkg::hdr_status_t              status
);

    logic [7:0]      first_reg, first_next;
    logic [31:0]     size_reg, size_next;
    logic [31:0]     off_reg, off_next;
    bmpse_pkg::err_t err_reg, err_next;
    logic [31:0]     room;
    logic [1:0]      lane;

    // Parse header bytes and run the end-of-header checks
    always_comb
    begin
        first_next = first_reg;
        size_next  = size_reg;
        off_next   = off_reg;
        err_next   = err_reg;
        // Byte lane within the 32-bit field; wraps so offsets 2 and 10 map to lane 0
        lane       = pos_lo[1:0] - 2'd2;
        if (in_hdr)
        begin
            case (pos_lo) inside
                4'd0:
                begin
                    size_next  = '0;
                    off_next   = '0;
                    err_next   = bmpse_pkg::ERR_NONE;
                    first_next = image_byte;
                end
                4'd1:
                begin
                    if (first_reg != bmpse_pkg::MAGIC_B || image_byte != bmpse_pkg::MAGIC_M)
                        err_next = bmpse_pkg::ERR_MAGIC;
                end
                [4'd2:4'd5]:
                    size_next[8*lane +: 8] = size_reg[8*lane +: 8] | image_byte;
                [4'd10:4'd13]:
                    off_next[8*lane +: 8] = off_reg[8*lane +: 8] | image_byte;
                default:
                    ;
            endcase
        end
        room = size_reg - off_next;
        if (in_hdr && pos_lo == 4'd13 && err_reg == bmpse_pkg::ERR_NONE)
        begin
            if (off_next < 32'(bmpse_pkg::HEADER_BYTES) || off_next > size_reg)
                err_next = bmpse_pkg::ERR_OFFSET;
            else if (need > {1'b0, room})
                err_next = bmpse_pkg::ERR_SPACE;
        end
    end

    // Hold header fields between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            size_reg  <= '0;
            off_reg   <= '0;
            err_reg   <= bmpse_pkg::ERR_NONE;
        end
        else if (take)
        begin
            first_reg <= first_next;
            size_reg  <= size_next;
            off_reg   <= off_next;
            err_reg   <= err_next;
        end
    end

    assign status.err          = err_next;
    assign status.pixel_offset = off_reg;

endmodule

>>> design/bmp_lsb_stego_embed_core.sv
`timescale 1ns / 1ps

// Channel   | Dir | Payload                                              | Handshake
// ----------+-----+------------------------------------------------------+----------
// image     | in  | image_byte, payload_byte, file_last                  | valid/ready
// result    | out | out_byte, byte_role, error_code, payload_advance,    | valid/ready
//           |     | out_last                                             |
// cfg       | in  | cfg_wr_data (payload_length)                         | cfg_wr_en
//
// One byte per cycle while the result sink is not stalled; each byte's result appears
// in the cycle after its transfer. The output register frees its slot in the same
// cycle it is taken, so input ready only drops when a result is held and the sink is
// stalled. Reset clears position, header fields, error and payload_length.

module bmp_lsb_stego_embed_core
#(
    parameter int unsigned LENGTH_BITS = bmpse_pkg::LENGTH_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    bmpse_in_if.sink                      image,
    bmpse_out_if.source                   result,
    input  logic                          cfg_wr_en,
    input  logic [bmpse_pkg::PLEN_W-1:0]  cfg_wr_data
);

    localparam logic [bmpse_pkg::NEED_W-1:0] LB_W = bmpse_pkg::NEED_W'(LENGTH_BITS);
    localparam logic [2:0]                   LB_LO = 3'(LENGTH_BITS);

    logic [bmpse_pkg::PLEN_W-1:0] plen_reg;
    logic [bmpse_pkg::NEED_W-1:0] need_reg;
    logic [31:0]                  pos_reg, pos_next;
    bmpse_pkg::out_item_t         out_reg, out_next;
    logic                         out_valid_reg;
    logic                         take;
    logic                         in_hdr;
    bmpse_pkg::hdr_status_t       hdr;
    logic [31:0]                  rel;
    logic [31:0]                  plen32;
    logic [2:0]                   k;

    assign take        = image.valid && image.ready;
    assign image.ready = !out_valid_reg || result.ready;
    assign in_hdr      = (pos_reg < 32'(bmpse_pkg::HEADER_BYTES));

    // Latch the length register and the room it needs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            need_reg <= LB_W;
        end
        else if (cfg_wr_en)
        begin
            plen_reg <= cfg_wr_data;
            need_reg <= {1'b0, cfg_wr_data, 3'b000} + LB_W;
        end
    end

    bmpse_hdr u_hdr
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .in_hdr     (in_hdr),
        .pos_lo     (pos_reg[3:0]),
        .image_byte (image.data.image_byte),
        .need       (need_reg),
        .status     (hdr)
    );

    // Classify the byte and replace its LSB where a bit is hidden
    always_comb
    begin
        rel    = pos_reg - hdr.pixel_offset;
        plen32 = {3'b000, plen_reg};
        k      = rel[2:0] - LB_LO;
        out_next.out_byte        = image.data.image_byte;
        out_next.byte_role       = bmpse_pkg::ROLE_POST;
        out_next.error_code      = hdr.err;
        out_next.payload_advance = 1'b0;
        out_next.out_last        = image.data.file_last;
        if (in_hdr)
            out_next.byte_role = bmpse_pkg::ROLE_HEADER;
        else if (hdr.err != bmpse_pkg::ERR_NONE)
            out_next.byte_role = bmpse_pkg::ROLE_POST;
        else if (pos_reg < hdr.pixel_offset)
            out_next.byte_role = bmpse_pkg::ROLE_PRE;
        else if ({1'b0, rel} < LB_W)
        begin
            out_next.out_byte[0] = plen32[rel[4:0]];
            out_next.byte_role   = bmpse_pkg::ROLE_LEN;
        end
        else if ({1'b0, rel} < need_reg)
        begin
            out_next.out_byte[0]     = image.data.payload_byte[k];
            out_next.byte_role       = bmpse_pkg::ROLE_PAY;
            out_next.payload_advance = (k == 3'd7);
        end
    end

    // Advance the byte position, restarting after the last byte and saturating on very long files
    always_comb
    begin
        if (image.data.file_last)
            pos_next = '0;
        else if (&pos_reg)
            pos_next = pos_reg;
        else
            pos_next = pos_reg + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (take)
            pos_reg <= pos_next;
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

>>> design/bmpse_checker.sv
`timescale 1ns / 1ps

module bmpse_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] role,
    input  logic [1:0] err,
    input  logic       advance
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // An empty output slot always takes input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output slot");

    // Payload advance only on payload carrier bytes
    a_adv_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && advance |-> role == bmpse_pkg::ROLE_PAY)
        else $error("payload advance outside payload bytes");

    // After an error no byte past the header carries a bit
    a_err_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && err != bmpse_pkg::ERR_NONE && role != bmpse_pkg::ROLE_HEADER
            |-> role == bmpse_pkg::ROLE_POST)
        else $error("embedding despite header error");

    // A transfer always yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("transfer produced no result");

endmodule

bind bmp_lsb_stego_embed_core bmpse_checker u_bmpse_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (image.valid),
    .in_ready  (image.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .role      (result.data.byte_role),
    .err       (result.data.error_code),
    .advance   (result.data.payload_advance)
);
